>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion that is off while reset is high
`define CRB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also holds during reset
`define CRB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/crb_pkg.sv
// types, constants and microcode table of the cubic bisection root finder
package crb_pkg;

   // number format and search limits
   localparam int FRAC_BITS = 16;
   localparam int MAX_STEPS = 32;
   localparam int DATA_W    = 32;
   localparam int TOL_W     = 31;
   localparam int STEP_W    = $clog2(MAX_STEPS + 1);
   localparam int UPC_W     = 5;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_IDX_W = 3;

   localparam logic [TOL_W-1:0] TOL_RESET = 31'd7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_COEFF_CUBIC  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEFF_SQUARE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEFF_LINEAR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEFF_CONST  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE    = 3'd4;

   // result status codes
   localparam logic [1:0] ST_FOUND  = 2'd0;
   localparam logic [1:0] ST_NOSIGN = 2'd1;
   localparam logic [1:0] ST_BAD    = 2'd2;

   // evaluation point select
   localparam logic [1:0] XS_NONE = 2'd0;
   localparam logic [1:0] XS_LO   = 2'd1;
   localparam logic [1:0] XS_HI   = 2'd2;
   localparam logic [1:0] XS_MID  = 2'd3;

   // coefficient select for the horner add
   localparam logic [1:0] CS_SQUARE = 2'd0;
   localparam logic [1:0] CS_LINEAR = 2'd1;
   localparam logic [1:0] CS_CONST  = 2'd2;

   // jump conditions
   localparam logic [2:0] JC_NONE     = 3'd0;
   localparam logic [2:0] JC_ALWAYS   = 3'd1;
   localparam logic [2:0] JC_NOREQ    = 3'd2;
   localparam logic [2:0] JC_BAD      = 3'd3;
   localparam logic [2:0] JC_NOSIGN   = 3'd4;
   localparam logic [2:0] JC_CONTINUE = 3'd5;

   // program addresses
   localparam logic [UPC_W-1:0] A_IDLE     = 5'd0;
   localparam logic [UPC_W-1:0] A_START_LO = 5'd1;
   localparam logic [UPC_W-1:0] A_START_HI = 5'd8;
   localparam logic [UPC_W-1:0] A_CHECK    = 5'd15;
   localparam logic [UPC_W-1:0] A_LOOP     = 5'd16;
   localparam logic [UPC_W-1:0] A_UPDATE   = 5'd23;
   localparam logic [UPC_W-1:0] A_DONE     = 5'd24;
   localparam logic [UPC_W-1:0] A_BAD      = 5'd25;
   localparam logic [UPC_W-1:0] A_NOSIGN   = 5'd26;

   // one control word of the program
   typedef struct packed {
      logic [1:0]       x_sel;
      logic             mul;
      logic             add;
      logic [1:0]       coef_sel;
      logic             save_flo;
      logic             clr_n;
      logic             update;
      logic             emit;
      logic [1:0]       status;
      logic [2:0]       jcond;
      logic [UPC_W-1:0] target;
   } ctrl_word_type;

   // datapath conditions seen by the sequencer
   typedef struct packed {
      logic bad;
      logic nosign;
      logic finish;
   } dp_flags_type;

   // program rom: three horner evaluations, the search loop and the results
   function automatic ctrl_word_type ucode(input logic [UPC_W-1:0] addr);
      ctrl_word_type cw;
      cw = '0;
      case (addr)
         A_IDLE: begin
            cw.jcond  = JC_NOREQ;
            cw.target = A_IDLE;
         end
         A_START_LO: begin
            cw.x_sel  = XS_LO;
            cw.jcond  = JC_BAD;
            cw.target = A_BAD;
         end
         A_START_HI: begin
            cw.x_sel    = XS_HI;
            cw.save_flo = 1'b1;
         end
         A_CHECK: begin
            cw.clr_n  = 1'b1;
            cw.jcond  = JC_NOSIGN;
            cw.target = A_NOSIGN;
         end
         A_LOOP: begin
            cw.x_sel = XS_MID;
         end
         A_START_LO + 5'd1, A_START_HI + 5'd1, A_LOOP + 5'd1,
         A_START_LO + 5'd3, A_START_HI + 5'd3, A_LOOP + 5'd3,
         A_START_LO + 5'd5, A_START_HI + 5'd5, A_LOOP + 5'd5: begin
            cw.mul = 1'b1;
         end
         A_START_LO + 5'd2, A_START_HI + 5'd2, A_LOOP + 5'd2: begin
            cw.add      = 1'b1;
            cw.coef_sel = CS_SQUARE;
         end
         A_START_LO + 5'd4, A_START_HI + 5'd4, A_LOOP + 5'd4: begin
            cw.add      = 1'b1;
            cw.coef_sel = CS_LINEAR;
         end
         A_START_LO + 5'd6, A_START_HI + 5'd6, A_LOOP + 5'd6: begin
            cw.add      = 1'b1;
            cw.coef_sel = CS_CONST;
         end
         A_UPDATE: begin
            cw.update = 1'b1;
            cw.jcond  = JC_CONTINUE;
            cw.target = A_LOOP;
         end
         A_DONE: begin
            cw.emit   = 1'b1;
            cw.status = ST_FOUND;
            cw.jcond  = JC_ALWAYS;
            cw.target = A_IDLE;
         end
         A_BAD: begin
            cw.emit   = 1'b1;
            cw.status = ST_BAD;
            cw.jcond  = JC_ALWAYS;
            cw.target = A_IDLE;
         end
         A_NOSIGN: begin
            cw.emit   = 1'b1;
            cw.status = ST_NOSIGN;
            cw.jcond  = JC_ALWAYS;
            cw.target = A_IDLE;
         end
         default: begin
            cw.jcond  = JC_ALWAYS;
            cw.target = A_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

>>> rtl/crb_datapath.sv
// interval registers, horner multiply/add unit and search condition logic
module crb_datapath
   import crb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_word_type             cw,
   input  logic                      load_in,
   input  logic signed [DATA_W-1:0]  x_low,
   input  logic signed [DATA_W-1:0]  x_high,
   input  logic signed [DATA_W-1:0]  coeff_cubic,
   input  logic signed [DATA_W-1:0]  coeff_square,
   input  logic signed [DATA_W-1:0]  coeff_linear,
   input  logic signed [DATA_W-1:0]  coeff_const,
   input  logic        [TOL_W-1:0]   tolerance,
   output logic signed [DATA_W-1:0]  lo,
   output dp_flags_type              flags
);

   logic signed [DATA_W-1:0]   lo_ff, hi_ff, x_ff, p_ff;
   logic signed [DATA_W-1:0]   x_in, p_in;
   logic signed [2*DATA_W-1:0] prod_ff;
   logic                       flo_pos_ff, flo_neg_ff;
   logic [STEP_W-1:0]          n_ff, n_in;

   logic signed [DATA_W:0]     mid_sum;
   logic signed [DATA_W-1:0]   mid;
   logic signed [DATA_W-1:0]   coef;
   logic signed [2*DATA_W-1:0] shifted;
   logic signed [DATA_W-1:0]   prod_sat;
   logic signed [DATA_W:0]     sum;
   logic signed [DATA_W-1:0]   sum_sat;
   logic                       p_zero, p_pos, p_neg, move_lo;
   logic signed [DATA_W:0]     width_next;

   // floor of the interval midpoint
   assign mid_sum = {lo_ff[DATA_W-1], lo_ff} + {hi_ff[DATA_W-1], hi_ff};
   assign mid     = mid_sum[DATA_W:1];

   // coefficient for the current horner add
   always_comb begin
      case (cw.coef_sel)
         CS_SQUARE: coef = coeff_square;
         CS_LINEAR: coef = coeff_linear;
         CS_CONST:  coef = coeff_const;
         default:   coef = coeff_const;
      endcase
   end

   // rescale product, saturate, add coefficient, saturate
   assign shifted = prod_ff >>> FRAC_BITS;
   always_comb begin
      if (shifted[2*DATA_W-1:DATA_W-1] == {(DATA_W+1){shifted[DATA_W-1]}}) begin
         prod_sat = shifted[DATA_W-1:0];
      end else begin
         prod_sat = {shifted[2*DATA_W-1], {(DATA_W-1){~shifted[2*DATA_W-1]}}};
      end
      sum = {prod_sat[DATA_W-1], prod_sat} + {coef[DATA_W-1], coef};
      if (sum[DATA_W] == sum[DATA_W-1]) begin
         sum_sat = sum[DATA_W-1:0];
      end else begin
         sum_sat = {sum[DATA_W], {(DATA_W-1){~sum[DATA_W]}}};
      end
   end

   // sign of the last evaluation and half selection
   assign p_zero  = (p_ff == '0);
   assign p_neg   = p_ff[DATA_W-1];
   assign p_pos   = ~p_neg & ~p_zero;
   assign move_lo = (flo_pos_ff & p_pos) | (flo_neg_ff & p_neg);

   // width of the interval after this halving
   always_comb begin
      if (move_lo || p_zero) begin
         width_next = {hi_ff[DATA_W-1], hi_ff} - {x_ff[DATA_W-1], x_ff};
      end else begin
         width_next = {x_ff[DATA_W-1], x_ff} - {lo_ff[DATA_W-1], lo_ff};
      end
   end

   assign n_in = n_ff + STEP_W'(1);

   assign flags.bad    = (lo_ff >= hi_ff);
   assign flags.nosign = (flo_pos_ff & p_pos) | (flo_neg_ff & p_neg);
   assign flags.finish = p_zero || (n_in == STEP_W'(MAX_STEPS)) ||
                         (width_next < $signed({2'b00, tolerance}));
   assign lo = lo_ff;

   // evaluation point select
   always_comb begin
      case (cw.x_sel)
         XS_LO:   x_in = lo_ff;
         XS_HI:   x_in = hi_ff;
         XS_MID:  x_in = mid;
         default: x_in = x_ff;
      endcase
   end

   // horner accumulator
   always_comb begin
      p_in = p_ff;
      if (cw.x_sel != XS_NONE) begin
         p_in = coeff_cubic;
      end else if (cw.add) begin
         p_in = sum_sat;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      p_ff <= p_in;
      if (cw.mul) begin
         prod_ff <= (2*DATA_W)'(p_ff) * (2*DATA_W)'(x_ff);
      end
      if (load_in) begin
         lo_ff <= x_low;
         hi_ff <= x_high;
      end else if (cw.update) begin
         if (move_lo || p_zero) begin
            lo_ff <= x_ff;
         end else begin
            hi_ff <= x_ff;
         end
      end
      if (cw.save_flo) begin
         flo_pos_ff <= p_pos;
         flo_neg_ff <= p_neg;
      end
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
      end else if (cw.clr_n) begin
         n_ff <= '0;
      end else if (cw.update) begin
         n_ff <= n_in;
      end
   end

endmodule

>>> rtl/cubic_root_bisection.sv
// top level: bisection root finder for a cubic in signed q16.16
// Usage:
//   req channel carries one search interval per transfer (x_low, x_high).
//   rsp channel returns one result per interval (root, status).
//   csr port writes the four coefficients and the stop tolerance; write
//   only while no interval is in flight.
// How it runs:
//   a control program in a rom drives one shared horner unit, one word per
//   cycle unless it holds on a result word. each evaluation of the cubic is a
//   load, then three multiply and saturating add pairs; each halving is an
//   evaluation at the midpoint and an interval update. a bad interval is
//   answered before any evaluation, no sign change after the evaluations at
//   both ends, a found root after k halvings (k at most 32). one interval is in
//   work at a time; req_tready is high only while the program waits at its
//   idle word, which it reaches as the result is loaded.
// Reset clears the program counter, the result valid and the registers
// (coefficients 0, tolerance 7).
// Backpressure: a result waits in the output register; the program holds on
// its result word until that register is free, then returns to idle.
module cubic_root_bisection
   import crb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input intervals
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // x_low [31:0], x_high [63:32]
   // results
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // root [31:0], status [33:32], zero fill
   // register writes
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]      csr_wdata
);

   logic [UPC_W-1:0]         upc_ff, upc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_root_ff;
   logic [1:0]               rsp_status_ff;
   logic signed [DATA_W-1:0] coeff_cubic_ff, coeff_square_ff;
   logic signed [DATA_W-1:0] coeff_linear_ff, coeff_const_ff;
   logic [TOL_W-1:0]         tolerance_ff;

   ctrl_word_type            cw, cw_live;
   dp_flags_type             flags;
   logic signed [DATA_W-1:0] lo;
   logic                     accept, stall, take_jump;

   // program rom read and handshake
   assign cw         = ucode(upc_ff);
   assign req_tready = (upc_ff == A_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign stall      = cw.emit & rsp_valid_ff & ~rsp_tready;

   // control word with its emit held back while the output is busy
   always_comb begin
      cw_live = cw;
      if (stall) begin
         cw_live.emit = 1'b0;
      end
   end

   // jump decision
   always_comb begin
      case (cw.jcond)
         JC_NONE:     take_jump = 1'b0;
         JC_ALWAYS:   take_jump = 1'b1;
         JC_NOREQ:    take_jump = ~req_tvalid;
         JC_BAD:      take_jump = flags.bad;
         JC_NOSIGN:   take_jump = flags.nosign;
         JC_CONTINUE: take_jump = ~flags.finish;
         default:     take_jump = 1'b1;
      endcase
   end

   // program counter
   always_comb begin
      if (stall) begin
         upc_in = upc_ff;
      end else if (take_jump) begin
         upc_in = cw.target;
      end else begin
         upc_in = upc_ff + UPC_W'(1);
      end
   end

   // output register valid
   always_comb begin
      if (cw_live.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= A_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cw_live.emit) begin
         rsp_status_ff <= cw.status;
         rsp_root_ff   <= (cw.status == ST_FOUND) ? lo : '0;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_cubic_ff  <= '0;
         coeff_square_ff <= '0;
         coeff_linear_ff <= '0;
         coeff_const_ff  <= '0;
         tolerance_ff    <= TOL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_COEFF_CUBIC:  coeff_cubic_ff  <= csr_wdata;
            REG_COEFF_SQUARE: coeff_square_ff <= csr_wdata;
            REG_COEFF_LINEAR: coeff_linear_ff <= csr_wdata;
            REG_COEFF_CONST:  coeff_const_ff  <= csr_wdata;
            REG_TOLERANCE:    tolerance_ff    <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   crb_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cw           (cw_live),
      .load_in      (accept),
      .x_low        (req_tdata[DATA_W-1:0]),
      .x_high       (req_tdata[2*DATA_W-1:DATA_W]),
      .coeff_cubic  (coeff_cubic_ff),
      .coeff_square (coeff_square_ff),
      .coeff_linear (coeff_linear_ff),
      .coeff_const  (coeff_const_ff),
      .tolerance    (tolerance_ff),
      .lo           (lo),
      .flags        (flags)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_root_ff};

endmodule

>>> rtl/crb_checker.sv
// port-level checks of the root finder, bound to the top level
`include "assert_macros.svh"

module crb_checker
   import crb_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   `CRB_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // only one interval in work: busy right after a transfer
   `CRB_ASSERT(a_busy_after_req, clock, reset, req_tvalid && req_tready |=> !req_tready, "input taken while busy")

   // a failed search reports a zero root
   `CRB_ASSERT(a_zero_root, clock, reset, rsp_tvalid && (rsp_tdata[33:32] == ST_NOSIGN || rsp_tdata[33:32] == ST_BAD) |-> rsp_tdata[31:0] == 32'd0, "nonzero root with failure status")

   // status is one of the defined codes
   `CRB_ASSERT(a_status_code, clock, reset, rsp_tvalid |-> (rsp_tdata[33:32] == ST_FOUND || rsp_tdata[33:32] == ST_NOSIGN || rsp_tdata[33:32] == ST_BAD), "undefined status code")

   // no result and ready for input right after reset
   `CRB_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid && req_tready, "not idle after reset")

endmodule

bind cubic_root_bisection crb_checker u_crb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
